### src/usv_pkg.sv
// ----------------------------------------------------------------------------
// usv_pkg
// Shared types and byte constants for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package usv_pkg;

  // single-byte characters
  localparam logic [7:0] ByteNul   = 8'h00;
  localparam logic [7:0] ByteTab   = 8'h09;
  localparam logic [7:0] ByteLf    = 8'h0A;
  localparam logic [7:0] ByteCr    = 8'h0D;
  localparam logic [7:0] AsciiLo   = 8'h20;
  localparam logic [7:0] AsciiHi   = 8'h7F;

  // lead bytes
  localparam logic [7:0] Lead2Lo   = 8'hC2;
  localparam logic [7:0] Lead2Hi   = 8'hDF;
  localparam logic [7:0] LeadE0    = 8'hE0;
  localparam logic [7:0] LeadED    = 8'hED;
  localparam logic [7:0] Lead3Hi   = 8'hEF;
  localparam logic [7:0] LeadF0    = 8'hF0;
  localparam logic [7:0] LeadF4    = 8'hF4;

  // continuation byte bounds
  localparam logic [7:0] ContLo    = 8'h80;
  localparam logic [7:0] ContHi    = 8'hBF;
  localparam logic [7:0] Cont8FHi  = 8'h8F;
  localparam logic [7:0] Cont90Lo  = 8'h90;
  localparam logic [7:0] Cont9FHi  = 8'h9F;
  localparam logic [7:0] ContA0Lo  = 8'hA0;

  // allowed range of the next continuation byte
  typedef enum logic [2:0] {
    RC_80_BF = 3'd0,
    RC_A0_BF = 3'd1,
    RC_80_9F = 3'd2,
    RC_90_BF = 3'd3,
    RC_80_8F = 3'd4
  } range_cls_e;

  typedef struct packed {
    logic [1:0] remaining;
    range_cls_e cls;
    logic       err;
  } usv_state_t;

  localparam usv_state_t StateIdle = '{remaining: 2'd0, cls: RC_80_BF, err: 1'b0};

endpackage

### src/usv_decode.sv
// ----------------------------------------------------------------------------
// usv_decode
// Next-state and verdict logic for one byte of the UTF-8 stream.
// ----------------------------------------------------------------------------
module usv_decode import usv_pkg::*; (
  input  usv_state_t state_i,
  input  logic [7:0] data_byte_i,
  output usv_state_t state_o,
  output logic       term_o,
  output logic       verdict_o
);

  logic cont_ok;
  logic is_single;

  always_comb begin
    case (state_i.cls)
      RC_A0_BF: cont_ok = (data_byte_i >= ContA0Lo) && (data_byte_i <= ContHi);
      RC_80_9F: cont_ok = (data_byte_i >= ContLo)   && (data_byte_i <= Cont9FHi);
      RC_90_BF: cont_ok = (data_byte_i >= Cont90Lo) && (data_byte_i <= ContHi);
      RC_80_8F: cont_ok = (data_byte_i >= ContLo)   && (data_byte_i <= Cont8FHi);
      default:  cont_ok = (data_byte_i >= ContLo)   && (data_byte_i <= ContHi);
    endcase
  end

  assign is_single = (data_byte_i == ByteTab) || (data_byte_i == ByteLf) ||
                     (data_byte_i == ByteCr) ||
                     ((data_byte_i >= AsciiLo) && (data_byte_i <= AsciiHi));

  assign term_o    = (data_byte_i == ByteNul);
  assign verdict_o = !state_i.err && (state_i.remaining == 2'd0);

  always_comb begin
    state_o = state_i;
    if (term_o) begin
      state_o = StateIdle;
    end else if (state_i.err) begin
      state_o = state_i;
    end else if (state_i.remaining != 2'd0) begin
      state_o.cls = RC_80_BF;
      if (cont_ok) begin
        state_o.remaining = state_i.remaining - 2'd1;
      end else begin
        state_o.remaining = 2'd0;
        state_o.err       = 1'b1;
      end
    end else begin
      // lead byte
      state_o.cls       = RC_80_BF;
      state_o.remaining = 2'd0;
      if (is_single) begin
        state_o.remaining = 2'd0;
      end else if ((data_byte_i >= Lead2Lo) && (data_byte_i <= Lead2Hi)) begin
        state_o.remaining = 2'd1;
      end else if (data_byte_i == LeadE0) begin
        state_o.remaining = 2'd2;
        state_o.cls       = RC_A0_BF;
      end else if (data_byte_i == LeadED) begin
        state_o.remaining = 2'd2;
        state_o.cls       = RC_80_9F;
      end else if ((data_byte_i > LeadE0) && (data_byte_i <= Lead3Hi)) begin
        state_o.remaining = 2'd2;
      end else if (data_byte_i == LeadF0) begin
        state_o.remaining = 2'd3;
        state_o.cls       = RC_90_BF;
      end else if (data_byte_i == LeadF4) begin
        state_o.remaining = 2'd3;
        state_o.cls       = RC_80_8F;
      end else if ((data_byte_i > LeadF0) && (data_byte_i < LeadF4)) begin
        state_o.remaining = 2'd3;
      end else begin
        state_o.err = 1'b1;
      end
    end
  end

endmodule

### src/utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Strict UTF-8 checker for a zero-terminated byte stream, one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   input channel : data_byte_i with in_valid_i / in_stall_o, one string byte
//                   per beat; a zero byte terminates the string
//   output channel: is_valid_o with out_valid_o / out_stall_i, one beat per
//                   terminator, 1 when the string since the previous
//                   terminator (or reset) was valid UTF-8
//   non-terminator bytes produce no output beat
// Timing:
//   a byte is captured in an input register, decoded against the sequence
//   state, and the verdict of a terminator lands in the output register
//   throughput is one byte per cycle, set by the single decode stage, while
//   no untaken verdict is held back by out_stall_i
// Reset:
//   rst_ni clears the sequence state and both pipeline valid flags
// Backpressure:
//   while the output register holds an untaken verdict and out_stall_i is
//   high, the decode stage holds and in_stall_o rises once the input
//   register is full; no beat is dropped
// ----------------------------------------------------------------------------
module utf8_stream_validator import usv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       is_valid_o,
  output logic       out_valid_o,
  input  logic       out_stall_i
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  usv_state_t st_q, st_d;
  logic       out_vld_q;
  logic       out_bit_q;
  logic       term;
  logic       verdict;
  logic       advance;
  logic       in_fire;

  usv_decode u_decode (
    .state_i     (st_q),
    .data_byte_i (in_byte_q),
    .state_o     (st_d),
    .term_o      (term),
    .verdict_o   (verdict)
  );

  // decode stage moves when the output register is free or draining
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_fire) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateIdle;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && term) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && term) begin
      out_bit_q <= verdict;
    end
  end

  assign out_valid_o = out_vld_q;
  assign is_valid_o  = out_bit_q;

`ifndef NO_ASSERTIONS
  // an error always abandons the open sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.err |-> (st_q.remaining == 2'd0))
    else $error("error flag set with continuation bytes pending");

  // narrowed ranges only follow a three- or four-byte lead
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.cls != RC_80_BF) |-> (st_q.remaining >= 2'd2))
    else $error("narrowed range class without a fresh multi-byte lead");

  // a terminator clears the state and raises a verdict beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && term) |=> (out_valid_o && (st_q == StateIdle)))
    else $error("terminator did not yield a verdict and a cleared state");

  // a non-terminator never creates a new verdict beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !(advance && term)) |=> !out_valid_o)
    else $error("verdict beat without a terminator");
`endif

endmodule

### verif/usv_checker.sv
// ----------------------------------------------------------------------------
// usv_checker
// Watches both channels of the UTF-8 stream validator, predicts the verdict
// for every terminator beat and compares it with the output beats in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usv_checker import usv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        is_valid_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  // shadow of the sequence state
  logic [1:0] seq_left;
  range_cls_e seq_cls;
  logic       seq_bad;

  bit verdict_q[$];

  function automatic bit cont_in_range(input logic [7:0] b, input range_cls_e cls);
    case (cls)
      RC_A0_BF: return b >= ContA0Lo && b <= ContHi;
      RC_80_9F: return b >= ContLo && b <= Cont9FHi;
      RC_90_BF: return b >= Cont90Lo && b <= ContHi;
      RC_80_8F: return b >= ContLo && b <= Cont8FHi;
      default:  return b >= ContLo && b <= ContHi;
    endcase
  endfunction

  // advance the shadow state by one byte; a terminator yields a verdict
  function automatic void utf8_decode_byte(input logic [7:0] b, output bit has_verdict,
                                           output bit verdict);
    has_verdict = 1'b0;
    verdict     = 1'b0;
    if (b == ByteNul) begin
      has_verdict = 1'b1;
      verdict     = !seq_bad && seq_left == 2'd0;
      seq_left    = 2'd0;
      seq_cls     = RC_80_BF;
      seq_bad     = 1'b0;
    end else if (seq_bad) begin
      // everything up to the terminator is dropped once the string is bad
    end else if (seq_left != 2'd0) begin
      if (cont_in_range(b, seq_cls)) begin
        seq_left = seq_left - 2'd1;
      end else begin
        seq_left = 2'd0;
        seq_bad  = 1'b1;
      end
      seq_cls = RC_80_BF;
    end else begin
      seq_cls = RC_80_BF;
      if (b == ByteTab || b == ByteLf || b == ByteCr || (b >= AsciiLo && b <= AsciiHi)) begin
        seq_left = 2'd0;
      end else if (b >= Lead2Lo && b <= Lead2Hi) begin
        seq_left = 2'd1;
      end else if (b == LeadE0) begin
        seq_left = 2'd2;
        seq_cls  = RC_A0_BF;
      end else if (b == LeadED) begin
        seq_left = 2'd2;
        seq_cls  = RC_80_9F;
      end else if (b > LeadE0 && b <= Lead3Hi) begin
        seq_left = 2'd2;
      end else if (b == LeadF0) begin
        seq_left = 2'd3;
        seq_cls  = RC_90_BF;
      end else if (b == LeadF4) begin
        seq_left = 2'd3;
        seq_cls  = RC_80_8F;
      end else if (b > LeadF0 && b < LeadF4) begin
        seq_left = 2'd3;
      end else begin
        seq_left = 2'd0;
        seq_bad  = 1'b1;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit has_verdict;
    bit verdict;
    if (!rst_ni) begin
      seq_left     = 2'd0;
      seq_cls      = RC_80_BF;
      seq_bad      = 1'b0;
      verdict_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $error("is_valid: unexpected beat, actual %0b", is_valid_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          verdict = verdict_q.pop_front();
          if (is_valid_i !== verdict) begin
            $error("is_valid mismatch: expected %0b, actual %0b", verdict, is_valid_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        utf8_decode_byte(data_byte_i, has_verdict, verdict);
        if (has_verdict) verdict_q.push_back(verdict);
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives zero-terminated byte strings into the UTF-8 stream validator: a
// directed opening, then random strings that are mostly well-formed with some
// broken sequences and noise. Sender bursts and receiver stalls are random;
// the checker beside the block predicts and compares each verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench import usv_pkg::*; ();

  localparam int unsigned RandomBytes = 1100;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned DrainCycles = 8;

  // plain, two-byte and narrowed-range leads, terminator inside a sequence, bytes after an error
  localparam logic [7:0] DirectedBytes [28] = '{
    8'h09, 8'h0A, 8'h0D, 8'h20, 8'h7F, 8'h00,
    8'hC2, 8'h80, 8'hE0, 8'hA0, 8'hBF, 8'hED, 8'h9F, 8'hBF,
    8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
    8'hE1, 8'h00,
    8'hFF, 8'h41, 8'h00
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       in_valid  = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       is_valid;
  logic       out_valid;

  int unsigned pending;
  int unsigned fail_count;

  logic [7:0]  str_q[$];
  int unsigned burst_left = 0;
  int unsigned sent_bytes = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_phase = 0;
  int unsigned stall_mode = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  utf8_stream_validator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .data_byte_i(data_byte),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .is_valid_o (is_valid),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall)
  );

  usv_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .data_byte_i (data_byte),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .is_valid_i  (is_valid),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  // receiver: picks a new random stall style whenever its phase counter runs out
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_phase <= $urandom_range(50, 300);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 9) < 3);
      2:       out_stall <= (stall_phase[4:0] < 5'd20);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // lo and hi biased toward the ends of the range
  function automatic logic [7:0] pick_edge(input logic [7:0] lo, input logic [7:0] hi);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return 8'($urandom_range(hi, lo));
    endcase
  endfunction

  // one well-formed character: 0 single byte, 1..3 for 2..4 byte sequences
  function automatic void make_char(input int unsigned kind, output logic [3:0][7:0] seq,
                                    output logic [3:0][7:0] lo, output logic [3:0][7:0] hi,
                                    output int unsigned len);
    lo  = {4{ContLo}};
    hi  = {4{ContHi}};
    seq = '0;
    len = kind + 1;
    case (kind)
      0: begin
        case ($urandom_range(0, 9))
          0:       seq[0] = ByteTab;
          1:       seq[0] = ByteLf;
          2:       seq[0] = ByteCr;
          3:       seq[0] = AsciiLo;
          4:       seq[0] = AsciiHi;
          default: seq[0] = 8'($urandom_range(AsciiHi, AsciiLo));
        endcase
      end
      1: seq[0] = pick_edge(Lead2Lo, Lead2Hi);
      2: begin
        case ($urandom_range(0, 3))
          0: begin
            seq[0] = LeadE0;
            lo[1]  = ContA0Lo;
          end
          1: begin
            seq[0] = LeadED;
            hi[1]  = Cont9FHi;
          end
          default: begin
            seq[0] = pick_edge(LeadE0 + 8'd1, Lead3Hi);
            if (seq[0] == LeadED) seq[0] = LeadED + 8'd1;
          end
        endcase
      end
      default: begin
        case ($urandom_range(0, 3))
          0: begin
            seq[0] = LeadF0;
            lo[1]  = Cont90Lo;
          end
          1: begin
            seq[0] = LeadF4;
            hi[1]  = Cont8FHi;
          end
          default: seq[0] = pick_edge(LeadF0 + 8'd1, LeadF4 - 8'd1);
        endcase
      end
    endcase
    for (int i = 1; i < len; i++) seq[i] = pick_edge(lo[i], hi[i]);
  endfunction

  function automatic void push_clean();
    logic [3:0][7:0] seq, lo, hi;
    int unsigned     len, k;
    k = $urandom_range(0, 9);
    make_char(k < 4 ? 0 : k < 6 ? 1 : k < 8 ? 2 : 3, seq, lo, hi, len);
    for (int i = 0; i < len; i++) str_q.push_back(seq[i]);
  endfunction

  function automatic void push_broken();
    logic [3:0][7:0] seq, lo, hi;
    int unsigned     len, pos;
    logic [7:0]      b;
    make_char($urandom_range(1, 3), seq, lo, hi, len);
    pos = $urandom_range(1, len - 1);
    case ($urandom_range(0, 3))
      0: begin
        // illegal lead or control byte
        case ($urandom_range(0, 3))
          0:       b = 8'($urandom_range(ContHi, ContLo));
          1:       b = pick_edge(8'hC0, 8'hC1);
          2:       b = pick_edge(LeadF4 + 8'd1, 8'hFF);
          default: begin
            b = pick_edge(8'h01, AsciiLo - 8'd1);
            if (b == ByteTab || b == ByteLf || b == ByteCr) b = 8'h1F;
          end
        endcase
        str_q.push_back(b);
      end
      1: begin
        // sequence cut short
        for (int i = 0; i < pos; i++) str_q.push_back(seq[i]);
      end
      2: begin
        // one continuation byte outside its range
        if ($urandom_range(0, 1)) seq[pos] = pick_edge(8'h01, lo[pos] - 8'd1);
        else seq[pos] = pick_edge(hi[pos] + 8'd1, 8'hFF);
        for (int i = 0; i < len; i++) str_q.push_back(seq[i]);
      end
      default: str_q.push_back(8'($urandom_range(255, 1)));
    endcase
  endfunction

  // present one beat, hold it until taken, then maybe leave a gap
  task automatic send_beat(input logic [7:0] b);
    logic        stalled;
    int unsigned gap;
    data_byte <= b;
    in_valid  <= 1'b1;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sent_bytes++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    int unsigned n_tok, bad_at;
    bit          broken;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DirectedBytes[i]) send_beat(DirectedBytes[i]);
    while (sent_bytes < RandomBytes) begin
      n_tok  = $urandom_range(0, 8);
      broken = ($urandom_range(0, 9) < 3);
      bad_at = $urandom_range(0, n_tok);
      for (int t = 0; t <= n_tok; t++) begin
        if (broken && t == bad_at) push_broken();
        if (t < n_tok) push_clean();
      end
      str_q.push_back(ByteNul);
      while (str_q.size() != 0) send_beat(str_q.pop_front());
    end
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
